// ===== src/ssf_pkg.sv =====
// Shared types and constants of the stepper/servo command follower.
// No dependencies; every design module of the block imports this package.
`timescale 1ns / 1ps

package ssf_pkg;

  localparam int unsigned POS_W       = 13;
  localparam int unsigned PULSE_W     = 13;
  localparam int unsigned POS_MAX     = 8191;
  localparam int unsigned BYTE_VALUES = 256;
  localparam int unsigned BYTE_FULL   = 255;

  localparam int unsigned SERVO_BASE        = 2000;
  localparam int unsigned SERVO_SPAN        = 2000;
  localparam int unsigned SERVO_FULL_DEG    = 180;
  localparam int unsigned SERVO_RESET_ANGLE = 90;

  localparam logic [3:0] COIL_OFF = 4'b0000;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_WSTART = 3'd1,
    KIND_WBYTE  = 3'd2,
    KIND_RBYTE  = 3'd3,
    KIND_SAMPLE = 3'd4
  } ssf_kind_e;

  // Decoded strobes of the transaction in the work stage.
  typedef struct packed {
    logic tick;
    logic wr_start;
    logic wr_byte;
    logic rd_byte;
    logic sample;
  } ssf_ctl_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [1:0] channel;
  } ssf_in_t;

  // Eight-phase half-step coil sequence.
  function automatic logic [3:0] coil_of(input logic [2:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0:    c = 4'b0001;
      3'd1:    c = 4'b0011;
      3'd2:    c = 4'b0010;
      3'd3:    c = 4'b0110;
      3'd4:    c = 4'b0100;
      3'd5:    c = 4'b1100;
      3'd6:    c = 4'b1000;
      3'd7:    c = 4'b1001;
      default: c = COIL_OFF;
    endcase
    return c;
  endfunction

endpackage

// ===== src/ssf_if.sv =====
// Valid/ready channel interfaces of the command follower.
// Command channel into the block and response channel out of it.
`timescale 1ns / 1ps

interface ssf_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;
  logic [1:0] channel;

  modport source (output valid, kind, data, channel, input ready);
  modport sink   (input valid, kind, data, channel, output ready);
endinterface

interface ssf_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coil_pattern;
  logic [12:0] servo_pulse;
  logic [7:0]  read_data;
  logic        at_target;
  logic [12:0] position;

  modport source (output valid, coil_pattern, servo_pulse, read_data, at_target, position,
                  input ready);
  modport sink   (input valid, coil_pattern, servo_pulse, read_data, at_target, position,
                  output ready);
endinterface

// ===== src/ssf_cmd.sv =====
// Write-byte decoder: servo pulse and scaled target registers.
// Depends on ssf_pkg; scale tables are built at elaboration.
`timescale 1ns / 1ps

module ssf_cmd #(
  parameter int unsigned FULL_TURN_STEPS = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ssf_pkg::ssf_ctl_t               ctl_i,
  input  logic [7:0]                      data_i,
  output logic [ssf_pkg::POS_W-1:0]       target_o,
  output logic [ssf_pkg::PULSE_W-1:0]     pulse_o
);
  import ssf_pkg::*;

  localparam int unsigned PulseReset =
    SERVO_BASE + (SERVO_RESET_ANGLE * SERVO_SPAN) / SERVO_FULL_DEG;

  logic [POS_W-1:0]   tgt_tab   [BYTE_VALUES];
  logic [PULSE_W-1:0] pulse_tab [BYTE_VALUES];

  logic               phase_q, phase_d;
  logic [POS_W-1:0]   tgt_q, tgt_d;
  logic [PULSE_W-1:0] pulse_q, pulse_d;

  for (genvar gi = 0; gi < BYTE_VALUES; gi++) begin : g_tab
    localparam int unsigned TgtRaw = (gi * FULL_TURN_STEPS) / BYTE_FULL;
    localparam int unsigned TgtSat = (TgtRaw > POS_MAX) ? POS_MAX : TgtRaw;
    localparam int unsigned Pulse  = SERVO_BASE + (gi * SERVO_SPAN) / SERVO_FULL_DEG;
    assign tgt_tab[gi]   = POS_W'(TgtSat);
    assign pulse_tab[gi] = PULSE_W'(Pulse);
  end

  always_comb begin
    phase_d = phase_q;
    tgt_d   = tgt_q;
    pulse_d = pulse_q;
    if (ctl_i.wr_start) begin
      phase_d = 1'b0;
    end
    if (ctl_i.wr_byte) begin
      if (!phase_q) begin
        pulse_d = pulse_tab[data_i];
        phase_d = 1'b1;
      end else begin
        tgt_d   = tgt_tab[data_i];
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      tgt_q   <= '0;
      pulse_q <= PULSE_W'(PulseReset);
    end else begin
      phase_q <= phase_d;
      tgt_q   <= tgt_d;
      pulse_q <= pulse_d;
    end
  end

  assign target_o = tgt_d;
  assign pulse_o  = pulse_d;

endmodule

// ===== src/ssf_motion.sv =====
// Half-step sequencer: position counter, phase index and coil drive.
// Depends on ssf_pkg for the coil sequence and widths.
`timescale 1ns / 1ps

module ssf_motion (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ssf_pkg::ssf_ctl_t         ctl_i,
  input  logic [ssf_pkg::POS_W-1:0] target_i,
  output logic [ssf_pkg::POS_W-1:0] pos_o,
  output logic [3:0]                coil_o
);
  import ssf_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [2:0]       ph_q, ph_d;
  logic [3:0]       coil_q, coil_d;

  always_comb begin
    pos_d  = pos_q;
    ph_d   = ph_q;
    coil_d = coil_q;
    if (ctl_i.tick) begin
      if (pos_q < target_i) begin
        ph_d   = ph_q + 3'd1;
        coil_d = coil_of(ph_q + 3'd1);
        pos_d  = pos_q + POS_W'(1);
      end else if (pos_q > target_i) begin
        ph_d   = ph_q - 3'd1;
        coil_d = coil_of(ph_q - 3'd1);
        pos_d  = pos_q - POS_W'(1);
      end else begin
        coil_d = COIL_OFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      ph_q   <= '0;
      coil_q <= COIL_OFF;
    end else begin
      pos_q  <= pos_d;
      ph_q   <= ph_d;
      coil_q <= coil_d;
    end
  end

  assign pos_o  = pos_d;
  assign coil_o = coil_d;

`ifndef SYNTHESIS
  a_pos_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (pos_q == $past(pos_q) || pos_q == $past(pos_q) + POS_W'(1) ||
         pos_q == $past(pos_q) - POS_W'(1)))
    else $error("position moved by more than one step");

  a_move_drives_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (pos_q != $past(pos_q)) |-> (coil_q != COIL_OFF && $countones(coil_q) <= 2))
    else $error("step taken without a valid coil pattern");
`endif

endmodule

// ===== src/ssf_light.sv =====
// Light sample store with round-robin read pointer.
// Depends on ssf_pkg for the control strobes.
`timescale 1ns / 1ps

module ssf_light #(
  parameter int unsigned LIGHT_CHANNELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssf_pkg::ssf_ctl_t ctl_i,
  input  logic [1:0]        channel_i,
  input  logic [7:0]        data_i,
  output logic [7:0]        rd_data_o
);
  import ssf_pkg::*;

  localparam int unsigned PtrW = (LIGHT_CHANNELS > 1) ? $clog2(LIGHT_CHANNELS) : 1;

  logic [7:0]      store_q [LIGHT_CHANNELS];
  logic [PtrW-1:0] ptr_q, ptr_d;

  for (genvar gi = 0; gi < LIGHT_CHANNELS; gi++) begin : g_store
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        store_q[gi] <= '0;
      end else if (ctl_i.sample && (32'(channel_i) == gi)) begin
        store_q[gi] <= data_i;
      end
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctl_i.rd_byte) begin
      ptr_d = (ptr_q == PtrW'(LIGHT_CHANNELS - 1)) ? '0 : ptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  assign rd_data_o = ctl_i.rd_byte ? store_q[ptr_q] : 8'd0;

`ifndef SYNTHESIS
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < LIGHT_CHANNELS)
    else $error("read pointer beyond last light channel");
`endif

endmodule

// ===== src/stepper_servo_command_follower_top.sv =====
// Stepper/servo command follower, top level. Uses ssf_pkg, ssf_if, ssf_cmd, ssf_motion, ssf_light.
// A command passes the input register, the single work stage and the result register in order.
// Throughput: one transaction per cycle unless the sink stalls; set by the single work stage.
// An input register keeps taking one more transaction while a response waits on a stalled sink.
// Reset (rst_ni low, asynchronous): stepper at step 0 with target 0, coils off, servo angle 90,
//   light samples and read pointer zero, both pipeline registers empty.
`timescale 1ns / 1ps

module stepper_servo_command_follower_top #(
  parameter int unsigned FULL_TURN_STEPS = 4096,
  parameter int unsigned LIGHT_CHANNELS  = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ssf_cmd_if.sink  cmd_i,
  ssf_rsp_if.source rsp_o
);
  import ssf_pkg::*;

  // Input register: holds one accepted command transaction.
  logic     in_vld_q, in_vld_d;
  ssf_in_t  in_q;

  // Result register.
  logic               out_vld_q, out_vld_d;
  logic [3:0]         coil_q;
  logic [PULSE_W-1:0] pulse_q;
  logic [7:0]         rdata_q;
  logic               at_tgt_q;
  logic [POS_W-1:0]   pos_q;

  logic     advance;   // result register can take a new response
  logic     work;      // the held command is executed this cycle
  logic     cmd_acc;
  ssf_ctl_t ctl;

  logic [POS_W-1:0]   tgt_next;
  logic [PULSE_W-1:0] pulse_next;
  logic [POS_W-1:0]   pos_next;
  logic [3:0]         coil_next;
  logic [7:0]         rdata_next;

  assign advance     = !out_vld_q || rsp_o.ready;
  assign work        = in_vld_q && advance;
  assign cmd_i.ready = !in_vld_q || advance;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // Capture a new transaction, or drop the slot once its command has executed.
  always_comb begin
    in_vld_d = in_vld_q;
    if (cmd_acc) begin
      in_vld_d = 1'b1;
    end else if (work) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      in_q <= '{kind: cmd_i.kind, data: cmd_i.data, channel: cmd_i.channel};
    end
  end

  // Decode the held command into strobes; everything is quiet unless it executes.
  always_comb begin
    ctl = '0;
    if (work) begin
      case (ssf_kind_e'(in_q.kind))
        KIND_TICK:   ctl.tick     = 1'b1;
        KIND_WSTART: ctl.wr_start = 1'b1;
        KIND_WBYTE:  ctl.wr_byte  = 1'b1;
        KIND_RBYTE:  ctl.rd_byte  = 1'b1;
        KIND_SAMPLE: ctl.sample   = 1'b1;
        default:     ctl          = '0;   // unused kinds still answer, change nothing
      endcase
    end
  end

  ssf_cmd #(
    .FULL_TURN_STEPS(FULL_TURN_STEPS)
  ) u_cmd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .data_i   (in_q.data),
    .target_o (tgt_next),
    .pulse_o  (pulse_next)
  );

  ssf_motion u_motion (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .target_i (tgt_next),
    .pos_o    (pos_next),
    .coil_o   (coil_next)
  );

  ssf_light #(
    .LIGHT_CHANNELS(LIGHT_CHANNELS)
  ) u_light (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .channel_i (in_q.channel),
    .data_i    (in_q.data),
    .rd_data_o (rdata_next)
  );

  // Load a response when a command executes; clear valid once the sink takes it.
  always_comb begin
    out_vld_d = out_vld_q;
    if (work) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // Response fields reflect state after the update.
  always_ff @(posedge clk_i) begin
    if (work) begin
      coil_q   <= coil_next;
      pulse_q  <= pulse_next;
      rdata_q  <= rdata_next;
      at_tgt_q <= (pos_next == tgt_next);
      pos_q    <= pos_next;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.coil_pattern = coil_q;
  assign rsp_o.servo_pulse  = pulse_q;
  assign rsp_o.read_data    = rdata_q;
  assign rsp_o.at_target    = at_tgt_q;
  assign rsp_o.position     = pos_q;

`ifndef SYNTHESIS
  a_held_cmd_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("held command lost while response stalled");

  a_work_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work |=> out_vld_q)
    else $error("executed command produced no response");
`endif

endmodule
